// ----- src/nbl_pkg.sv -----
// ----------------------------------------------------------------------------
// nbl_pkg
// Shared types and constants for the numeric bitwise logic pipeline.
// ----------------------------------------------------------------------------
package nbl_pkg;

	localparam logic [10:0] EXP_BIAS  = 11'd1023;
	localparam logic [10:0] EXP_MAX   = 11'h7FF;
	localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
	localparam logic [5:0]  MANT_TOP  = 6'd52;

	typedef enum logic [1:0] {
		MODE_BIT = 2'd0,
		MODE_XOR = 2'd1,
		MODE_OR  = 2'd2,
		MODE_AND = 2'd3
	} mode_t;

	// decoded operands
	typedef struct packed {
		logic               is_bit;
		logic               idx_int;
		logic               idx_in;
		logic signed [13:0] idx;
		logic               xneg;
		logic               is_xor;
		logic               ovr;
		logic [63:0]        ovr_val;
		logic [10:0]        e1;
		logic [10:0]        e2;
		logic [10:0]        d;
		logic [51:0]        m1;
		logic [51:0]        m2;
		logic               bn;
		logic               sn;
		logic               xs;
		logic               flip;
	} s1_t;

	// combined mantissa, waiting for renormalization
	typedef struct packed {
		logic        ovr;
		logic [63:0] val;
		logic        undef;
		logic [52:0] m;
		logic [10:0] e;
		logic        sign;
		logic        flip;
	} s2_t;

	// leading-one position found
	typedef struct packed {
		s2_t        base;
		logic [5:0] sh;
		logic       mz;
	} s3_t;

endpackage

// ----- src/nbl_decode.sv -----
// ----------------------------------------------------------------------------
// nbl_decode
// Stage 1: NaN and subnormal handling, operand swap, index decode.
// ----------------------------------------------------------------------------
module nbl_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    mode,
	input  logic [63:0]   x_bits,
	input  logic [63:0]   y_bits,
	output logic          valid_s1,
	output nbl_pkg::s1_t  s1
);
	import nbl_pkg::*;

	mode_t       md;
	logic        nan_x, nan_y;
	logic [63:0] xf, yf, p, q, big, small_op;
	logic [10:0] ye, ye_off;
	logic [51:0] ym, frac_low;
	logic [52:0] mag_full;
	logic [11:0] mag;
	logic        flip;
	s1_t         d1;

	assign md       = mode_t'(mode);
	assign nan_x    = (x_bits[62:52] == EXP_MAX) && (x_bits[51:0] != '0);
	assign nan_y    = (y_bits[62:52] == EXP_MAX) && (y_bits[51:0] != '0);
	assign xf       = (x_bits[62:52] == '0) ? {x_bits[63], 63'b0} : x_bits;
	assign yf       = (y_bits[62:52] == '0) ? {y_bits[63], 63'b0} : y_bits;
	assign flip     = (md == MODE_AND);
	assign p        = xf ^ {flip, 63'b0};
	assign q        = yf ^ {flip, 63'b0};
	assign big      = (p[62:0] < q[62:0]) ? q : p;
	assign small_op = (p[62:0] < q[62:0]) ? p : q;
	assign ye       = y_bits[62:52];
	assign ym       = y_bits[51:0];
	assign ye_off   = ye - EXP_BIAS;
	assign frac_low = ym << ye_off[5:0];
	assign mag_full = {1'b1, ym} >> (MANT_TOP - ye_off[5:0]);
	assign mag      = mag_full[11:0];

	// decode
	always_comb begin
		d1 = '0;
		d1.is_bit = (md == MODE_BIT);
		d1.is_xor = (md == MODE_XOR);
		d1.flip   = flip;
		// bit index: integer test and small integer value
		if (ye == EXP_MAX || ye == '0) begin
			d1.idx_int = (ym == '0);
		end else if (ye < EXP_BIAS) begin
			d1.idx_int = 1'b0;
		end else if (ye_off >= 11'd52) begin
			d1.idx_int = 1'b1;
		end else begin
			d1.idx_int = (frac_low == '0);
		end
		if (ye == '0) begin
			d1.idx_in = 1'b1;
			d1.idx    = '0;
		end else if (ye >= EXP_BIAS && ye_off <= 11'd11) begin
			d1.idx_in = 1'b1;
			d1.idx    = y_bits[63] ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
		end
		d1.xneg = xf[63] && (xf[62:0] != '0) && !nan_x;
		d1.xs   = xf[63] ^ yf[63];
		d1.bn   = big[63];
		d1.sn   = small_op[63];
		d1.e2   = small_op[62:52];
		d1.m2   = small_op[51:0];
		d1.d    = big[62:52] - small_op[62:52];
		if (md == MODE_BIT) begin
			d1.e1 = xf[62:52];
			d1.m1 = xf[51:0];
		end else begin
			d1.e1 = big[62:52];
			d1.m1 = big[51:0];
		end
		// results known right away
		if (md != MODE_BIT) begin
			if (nan_x || nan_y) begin
				d1.ovr     = 1'b1;
				d1.ovr_val = QNAN_BITS;
			end else begin
				case (md)
					MODE_XOR: begin
						if (xf[62:0] == '0) begin
							d1.ovr     = 1'b1;
							d1.ovr_val = yf;
						end else if (yf[62:0] == '0) begin
							d1.ovr     = 1'b1;
							d1.ovr_val = xf;
						end
					end
					MODE_OR: begin
						if (small_op[62:0] == '0) begin
							d1.ovr     = 1'b1;
							d1.ovr_val = big;
						end
					end
					MODE_AND: begin
						if (xf[62:0] == '0 || yf[62:0] == '0) begin
							d1.ovr     = 1'b1;
							d1.ovr_val = '0;
						end
					end
					default: begin
						d1.ovr = 1'b0;
					end
				endcase
			end
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		s1 <= d1;
	end

endmodule

// ----- src/nbl_combine.sv -----
// ----------------------------------------------------------------------------
// nbl_combine
// Stage 2: mantissa alignment and combine, bit pick for the bit mode.
// ----------------------------------------------------------------------------
module nbl_combine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  nbl_pkg::s1_t  s1,
	output logic          valid_s2,
	output nbl_pkg::s2_t  s2
);
	import nbl_pkg::*;

	logic signed [11:0] ex;
	logic signed [13:0] dd;
	logic [5:0]         bi;
	logic               b;
	logic               sat;
	logic [52:0]        m2h, sr, sl;
	logic               rn, sg;
	logic [52:0]        rm;
	logic [10:0]        ee;
	logic [51:0]        dm;
	s2_t                d2;

	assign ex  = $signed({1'b0, s1.e1}) - $signed({1'b0, EXP_BIAS});
	assign dd  = {{2{ex[11]}}, ex} - s1.idx;
	assign bi  = MANT_TOP - dd[5:0];
	assign sat = (s1.d >= 11'd53);
	assign m2h = {1'b1, s1.m2};
	assign sr  = sat ? '0 : (m2h >> s1.d[5:0]);
	assign sl  = sat ? '0 : (53'(s1.m1) << s1.d[5:0]);

	// bit of value at the requested position
	always_comb begin
		b = 1'b0;
		if (s1.idx_in && dd >= 14'sd0 && dd <= 14'sd52) begin
			if (dd == 14'sd0) begin
				b = (s1.e1 != '0);
			end else begin
				b = s1.m1[bi];
			end
		end
	end

	// numeric xor / or (and is or with complemented operands)
	always_comb begin
		rn = 1'b0;
		rm = '0;
		ee = s1.e1;
		dm = '0;
		sg = 1'b1;
		if (s1.is_xor) begin
			sg = s1.xs;
			if (s1.d != '0) begin
				dm = s1.m1 ^ sr[51:0];
			end else begin
				rn = 1'b1;
				rm = {1'b0, s1.m1 ^ s1.m2};
			end
		end else if (s1.d == '0) begin
			if (!s1.bn && !s1.sn) begin
				dm = s1.m1 | s1.m2;
				sg = 1'b0;
			end else if (s1.bn && s1.sn) begin
				dm = s1.m1 & s1.m2;
			end else begin
				rn = 1'b1;
				rm = s1.bn ? {1'b0, s1.m1 & ~s1.m2} : {1'b0, s1.m2 & ~s1.m1};
			end
		end else begin
			if (!s1.bn && !s1.sn) begin
				dm = s1.m1 | sr[51:0];
				sg = 1'b0;
			end else if (s1.bn && s1.sn) begin
				rn = 1'b1;
				rm = sl & m2h;
				ee = s1.e2;
			end else if (s1.bn) begin
				dm = s1.m1 & ~sr[51:0];
			end else begin
				rn = 1'b1;
				rm = m2h & ~sl;
				ee = s1.e2;
			end
		end
	end

	// result selection
	always_comb begin
		d2       = '0;
		d2.m     = rm;
		d2.e     = ee;
		d2.sign  = sg ^ s1.flip;
		d2.flip  = s1.flip;
		if (s1.is_bit) begin
			d2.ovr = 1'b1;
			if (!s1.idx_int) begin
				d2.undef = 1'b1;
				d2.val   = '0;
			end else begin
				d2.val = (b ^ s1.xneg) ? ONE_BITS : '0;
			end
		end else if (s1.ovr) begin
			d2.ovr = 1'b1;
			d2.val = s1.ovr_val;
		end else if (!rn) begin
			d2.ovr = 1'b1;
			d2.val = {sg ^ s1.flip, ee, dm};
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		s2 <= d2;
	end

endmodule

// ----- src/nbl_lzc.sv -----
// ----------------------------------------------------------------------------
// nbl_lzc
// Stage 3: leading-one search on the combined mantissa.
// ----------------------------------------------------------------------------
module nbl_lzc (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s2,
	input  nbl_pkg::s2_t  s2,
	output logic          valid_s3,
	output nbl_pkg::s3_t  s3
);
	import nbl_pkg::*;

	logic [5:0] k;
	s3_t        d3;

	// priority encoder, highest set bit wins
	always_comb begin
		k = '0;
		for (int i = 0; i < 53; i++) begin
			if (s2.m[i]) begin
				k = 6'(i);
			end
		end
		d3.base = s2;
		d3.sh   = MANT_TOP - k;
		d3.mz   = (s2.m == '0);
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		s3 <= d3;
	end

endmodule

// ----- src/nbl_pack.sv -----
// ----------------------------------------------------------------------------
// nbl_pack
// Stage 4: normalizing shift, underflow to zero, final packing.
// ----------------------------------------------------------------------------
module nbl_pack (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s3,
	input  nbl_pkg::s3_t  s3,
	output logic          valid_s4,
	output logic [63:0]   result_s4,
	output logic          undef_s4
);
	import nbl_pkg::*;

	logic [52:0]        mn;
	logic signed [12:0] en;
	logic [63:0]        r;

	assign mn = s3.base.m << s3.sh;
	assign en = $signed({2'b0, s3.base.e}) - $signed({7'b0, s3.sh});

	// pack
	always_comb begin
		if (s3.base.ovr) begin
			r = s3.base.val;
		end else if (s3.mz || en <= 13'sd0) begin
			r = {s3.base.flip, 63'b0};
		end else begin
			r = {s3.base.sign, en[10:0], mn[51:0]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_s4 <= r;
		undef_s4  <= s3.base.undef;
	end

endmodule

// ----- src/numeric_bitwise_logic_on_doubles_core.sv -----
// ----------------------------------------------------------------------------
// numeric_bitwise_logic_on_doubles_core
// A transaction is taken on every cycle that start is high; busy stays low,
// since the four-stage pipeline (decode, align/combine, leading-one search,
// normalize/pack) moves every cycle. Each result passes the four pipeline
// registers and appears on result_bits and undefined, for the one cycle
// that done is high; the receiver must take it then. Throughput is one
// transaction per clock.
// ----------------------------------------------------------------------------
module numeric_bitwise_logic_on_doubles_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [63:0] x_bits,
	input  logic [63:0] y_bits,
	output logic        done,
	output logic [63:0] result_bits,
	output logic        undefined
);
	import nbl_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	s1_t  s1;
	s2_t  s2;
	s3_t  s3;

	assign busy = 1'b0;

	// pipeline stages
	nbl_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mode     (mode),
		.x_bits   (x_bits),
		.y_bits   (y_bits),
		.valid_s1 (valid_s1),
		.s1       (s1)
	);

	nbl_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.s1       (s1),
		.valid_s2 (valid_s2),
		.s2       (s2)
	);

	nbl_lzc u_lzc (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.s2       (s2),
		.valid_s3 (valid_s3),
		.s3       (s3)
	);

	nbl_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.s3        (s3),
		.valid_s4  (done),
		.result_s4 (result_bits),
		.undef_s4  (undefined)
	);

	// checks
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && undefined |-> result_bits == 64'd0)
		else $error("undefined result is not zero");

	a_undef_mode: assert property (@(posedge clk) disable iff (!arst_n)
		done && undefined |-> $past(mode, 4) == MODE_BIT)
		else $error("undefined flag outside bit mode");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done)
		else $error("transaction lost in pipeline");

endmodule

// ----- verif/numeric_bitwise_logic_on_doubles_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// numeric_bitwise_logic_on_doubles_core_tb
// Drives bit-of-value and numeric xor/or/and transactions into the core: a
// directed table of extremes and special cases, then random operands built
// around nearby exponents. Results are checked by table or local predictor.
// ----------------------------------------------------------------------------
module numeric_bitwise_logic_on_doubles_core_tb;
	import nbl_pkg::*;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] HIDDEN   = 64'h0010_0000_0000_0000;
	localparam logic [63:0] FRAC     = HIDDEN - 64'd1;
	localparam int NUM_RANDOM = 400;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [63:0] x_bits;
	logic [63:0] y_bits;
	logic        done;
	logic [63:0] result_bits;
	logic        undefined;

	typedef struct {
		logic [63:0] bits;
		logic        undef;
	} answer_t;

	typedef struct {
		mode_t       op;
		logic [63:0] x;
		logic [63:0] y;
		logic        typed;
		logic [63:0] bits;
		logic        undef;
	} row_t;

	answer_t     pending_answers[$];
	int          mismatches;
	int          results_seen;
	int          bit_items;
	int          logic_items;

	numeric_bitwise_logic_on_doubles_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.x_bits(x_bits),
		.y_bits(y_bits),
		.done(done),
		.result_bits(result_bits),
		.undefined(undefined)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// field helpers
	function automatic int exp_field(logic [63:0] v);
		return int'(v[62:52]);
	endfunction

	function automatic logic is_nan(logic [63:0] v);
		return v[62:52] == 11'h7FF && (v & FRAC) != 0;
	endfunction

	function automatic logic [63:0] flush_denorm(logic [63:0] v);
		return (v[62:52] == 0) ? (v & SIGN_BIT) : v;
	endfunction

	function automatic logic [63:0] shr(logic [63:0] v, int d);
		return (d < 0 || d >= 64) ? 64'd0 : (v >> d);
	endfunction

	function automatic logic [63:0] shl(logic [63:0] v, int d);
		return (d < 0 || d >= 64) ? 64'd0 : (v << d);
	endfunction

	function automatic logic whole_position(logic [63:0] v);
		int ef;
		int sh;
		logic [63:0] m;
		ef = exp_field(v);
		m = v & FRAC;
		if (ef == 2047 || ef == 0) return m == 0;
		if (ef < 1023) return 1'b0;
		sh = ef - 1023;
		if (sh >= 52) return 1'b1;
		return (m & ((64'd1 << (52 - sh)) - 64'd1)) == 0;
	endfunction

	// put the leading one at the hidden bit and pack
	function automatic logic [63:0] normalize(logic [63:0] m, int e, logic [63:0] sign);
		int k;
		if (m == 0) return 64'd0;
		if ((m & HIDDEN) == 0) begin
			k = 63;
			while (m[k] == 1'b0) k--;
			e -= 52 - k;
			m = m << (52 - k);
		end
		m ^= HIDDEN;
		if (e <= 0) return 64'd0;
		return m | (64'(e) << 52) | sign;
	endfunction

	function automatic logic [63:0] value_bit(logic [63:0] xb, logic [63:0] ib,
			output logic undef);
		logic neg;
		logic [63:0] a;
		logic [63:0] b;
		int e;
		int d;
		real pos;
		undef = 1'b0;
		if (!whole_position(ib)) begin
			undef = 1'b1;
			return 64'd0;
		end
		xb = flush_denorm(xb);
		neg = xb[63] && (xb & ~SIGN_BIT) != 0 && !is_nan(xb);
		a = xb & ~SIGN_BIT;
		e = exp_field(a) - 1023;
		pos = $bitstoreal(ib);
		if (pos > real'(e) || pos < real'(e - 52)) begin
			b = 0;
		end else begin
			d = e - $rtoi(pos);
			if (d <= 0) b = (e == -1023) ? 64'd0 : 64'd1;
			else b = (a >> (52 - d)) & 64'd1;
		end
		if (neg) b ^= 64'd1;
		return (b != 0) ? ONE_BITS : 64'd0;
	endfunction

	function automatic logic [63:0] real_xor(logic [63:0] x, logic [63:0] y);
		logic [63:0] s;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] t;
		logic [63:0] m;
		int e1;
		int e2;
		if ((x & ~SIGN_BIT) == 0) return y;
		if ((y & ~SIGN_BIT) == 0) return x;
		s = (x ^ y) & SIGN_BIT;
		a = x & ~SIGN_BIT;
		b = y & ~SIGN_BIT;
		if (a < b) begin
			t = a;
			a = b;
			b = t;
		end
		e1 = exp_field(a);
		e2 = exp_field(b);
		if (e1 > e2) begin
			m = (a & FRAC) ^ shr((b & FRAC) | HIDDEN, e1 - e2);
			return m | (64'(e1) << 52) | s;
		end
		return normalize((a ^ b) & FRAC, e1, s);
	endfunction

	function automatic logic [63:0] real_or(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		logic [63:0] m1;
		logic [63:0] m2;
		logic [63:0] m;
		logic xn;
		logic yn;
		int e1;
		int e2;
		int d;
		if ((x & ~SIGN_BIT) < (y & ~SIGN_BIT)) begin
			t = x;
			x = y;
			y = t;
		end
		if ((y & ~SIGN_BIT) == 0) return x;
		e1 = exp_field(x);
		e2 = exp_field(y);
		m1 = x & FRAC;
		m2 = y & FRAC;
		xn = x[63];
		yn = y[63];
		if (e1 == e2) begin
			if (!xn && !yn) return (m1 | m2) | (64'(e1) << 52);
			if (xn && yn) return (m1 & m2) | (64'(e1) << 52) | SIGN_BIT;
			m = xn ? (m1 & ~m2) : (~m1 & m2);
			return normalize(m, e1, SIGN_BIT);
		end
		d = e1 - e2;
		if (!xn && !yn) begin
			if (d > 52) return x;
			return m1 | ((m2 | HIDDEN) >> d) | (64'(e1) << 52);
		end
		m2 |= HIDDEN;
		if (xn && yn) begin
			if (d > 53) return 64'd0;
			return normalize(shl(m1, d) & m2, e2, SIGN_BIT);
		end
		if (xn) begin
			m = m1 & ~shr(m2 << 11, 11 + d);
			return m | (64'(e1) << 52) | SIGN_BIT;
		end
		return normalize(~shl(m1, d) & m2, e2, SIGN_BIT);
	endfunction

	function automatic answer_t predict_result(mode_t op, logic [63:0] x, logic [63:0] y);
		answer_t r;
		r.undef = 1'b0;
		if (op == MODE_BIT) begin
			r.bits = value_bit(x, y, r.undef);
		end else if (is_nan(x) || is_nan(y)) begin
			r.bits = QNAN_BITS;
		end else begin
			x = flush_denorm(x);
			y = flush_denorm(y);
			case (op)
				MODE_XOR: r.bits = real_xor(x, y);
				MODE_OR:  r.bits = real_or(x, y);
				default: begin
					if ((x & ~SIGN_BIT) == 0 || (y & ~SIGN_BIT) == 0) r.bits = 64'd0;
					else r.bits = real_or(x ^ SIGN_BIT, y ^ SIGN_BIT) ^ SIGN_BIT;
				end
			endcase
		end
		return r;
	endfunction

	// random operand, weighted toward normal values with special values mixed in
	function automatic logic [63:0] random_double();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0: v = v & SIGN_BIT;
			1: v = (v & SIGN_BIT) | 64'h7FF0_0000_0000_0000;
			2: v = v | 64'h7FF0_0000_0000_0001;
			3: v = v & 64'h800F_FFFF_FFFF_FFFF;
			4: ;
			5: v[62:52] = 11'(1023 + $urandom_range(0, 53));
			default: begin
				v[62:52] = 11'(1023 - 40 + $urandom_range(0, 80));
				if ($urandom_range(0, 2) == 0) v[30:0] = 0;
			end
		endcase
		return v;
	endfunction

	// second operand, often close in exponent to the first, so alignment is exercised
	function automatic logic [63:0] partner_of(logic [63:0] x);
		logic [63:0] v;
		int e;
		v = random_double();
		if ($urandom_range(0, 9) < 5 && x[62:52] != 0 && x[62:52] != 11'h7FF) begin
			e = exp_field(x) - $urandom_range(0, 60);
			if ($urandom_range(0, 2) == 0) e = exp_field(x);
			if (e < 1) e = 1;
			v[62:52] = 11'(e);
		end
		return v;
	endfunction

	// integer position around the value's significant bits, or any pattern
	function automatic logic [63:0] position_for(logic [63:0] x);
		int pos;
		if ($urandom_range(0, 9) < 7) begin
			pos = exp_field(x) - 1023 - 55 + $urandom_range(0, 58);
			return $realtobits(real'(pos));
		end
		return random_double();
	endfunction

	// result check: oldest expectation first
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h undef %b", result_bits, undefined);
			end else begin
				want = pending_answers.pop_front();
				if (result_bits !== want.bits || undefined !== want.undef) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b, got %h/%b",
							want.bits, want.undef, result_bits, undefined);
				end
			end
		end
	end

	// one transaction: hold until taken, then queue its expectation
	task automatic issue(mode_t op, logic [63:0] x, logic [63:0] y, logic typed,
			logic [63:0] bits, logic undef);
		answer_t want;
		start  <= 1'b1;
		mode   <= op;
		x_bits <= x;
		y_bits <= y;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (typed) begin
			want.bits = bits;
			want.undef = undef;
		end else begin
			want = predict_result(op, x, y);
		end
		pending_answers.push_back(want);
		if (op == MODE_BIT) bit_items++;
		else logic_items++;
	endtask

	task automatic maybe_gap(inout int burst_left);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 12);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		row_t rows[$];
		int burst_left;
		int waited;
		mode_t op;
		logic [63:0] x;
		mismatches = 0;
		results_seen = 0;
		bit_items = 0;
		logic_items = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		mode   = MODE_BIT;
		x_bits = 64'd0;
		y_bits = 64'd0;

		// directed: extremes and special cases
		rows = '{
			'{MODE_BIT, ONE_BITS, 64'd0, 1'b1, ONE_BITS, 1'b0},
			'{MODE_BIT, ONE_BITS, 64'h3FE0_0000_0000_0000, 1'b1, 64'd0, 1'b1},
			'{MODE_BIT, ONE_BITS, 64'h7FF8_0000_0000_0000, 1'b1, 64'd0, 1'b1},
			'{MODE_BIT, ONE_BITS, 64'h0000_0000_0000_0001, 1'b1, 64'd0, 1'b1},
			'{MODE_BIT, ONE_BITS, 64'h7FF0_0000_0000_0000, 1'b1, 64'd0, 1'b0},
			'{MODE_BIT, 64'hBFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b1, ONE_BITS, 1'b0},
			'{MODE_BIT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 64'd0, 1'b0},
			'{MODE_BIT, 64'h800F_FFFF_FFFF_FFFF, 64'd0, 1'b1, 64'd0, 1'b0},
			'{MODE_BIT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h4090_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_BIT, 64'hC008_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_BIT, 64'h3FFF_FFFF_FFFF_FFFF, 64'hC04A_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_XOR, 64'd0, 64'h4000_0000_0000_0000, 1'b1, 64'h4000_0000_0000_0000, 1'b0},
			'{MODE_XOR, 64'h7FF0_0000_0000_0001, ONE_BITS, 1'b1, QNAN_BITS, 1'b0},
			'{MODE_OR, ONE_BITS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, QNAN_BITS, 1'b0},
			'{MODE_AND, 64'h0000_0000_0000_0001, ONE_BITS, 1'b1, 64'd0, 1'b0},
			'{MODE_XOR, 64'h3FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_XOR, 64'h0010_0000_0000_0001, 64'h0010_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_XOR, 64'h7FE0_0000_0000_0000, 64'h0010_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_OR, 64'hC000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_OR, 64'hBFF8_0000_0000_0000, 64'hBFF4_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_OR, 64'h4330_0000_0000_0001, 64'hBCB0_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_OR, 64'h7FF0_0000_0000_0000, 64'hC010_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_AND, 64'hFFF0_0000_0000_0000, 64'h4028_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_AND, 64'hC01C_0000_0000_0000, 64'hC014_0000_0000_0000, 1'b0, 0, 0},
			'{MODE_AND, 64'h8000_0000_0000_0000, 64'hFFEF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			maybe_gap(burst_left);
			issue(rows[i].op, rows[i].x, rows[i].y, rows[i].typed, rows[i].bits,
				rows[i].undef);
		end

		// random part, bursty sender
		for (int n = 0; n < NUM_RANDOM; n++) begin
			maybe_gap(burst_left);
			op = mode_t'($urandom_range(0, 3));
			x = random_double();
			if (op == MODE_BIT) issue(op, x, position_for(x), 1'b0, 0, 0);
			else issue(op, x, partner_of(x), 1'b0, 0, 0);
		end
		start <= 1'b0;

		// drain
		waited = 0;
		while (pending_answers.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		$display("covered %0d bit-of-value and %0d xor/or/and transactions, %0d results",
			bit_items, logic_items, results_seen);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				pending_answers.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
